FILE: rtl/crcf_pkg.sv
`default_nettype none
package crcf_pkg;

  localparam int unsigned LenW        = 6;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CrcW        = 16;
  localparam logic [LenW-1:0]  LenMin = 6'd1;
  localparam logic [LenW-1:0]  LenMax = 6'd59;
  localparam logic [CrcW-1:0]  CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly = 16'h1021;
  localparam logic [CrcW-1:0]  SyncWord = 16'hAA55;
  localparam int unsigned FifoDepthDef = 4;

  typedef enum logic [2:0] {
    PH_SYNC0,
    PH_SYNC1,
    PH_LEN,
    PH_DATA,
    PH_CRCLO,
    PH_CRCHI
  } crcf_phase_e;

  // one classified payload word handed from front to back
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] len_byte;
    logic [CrcW-1:0]  crc;
    logic             first;
    logic             last;
  } crcf_entry_t;

  // crc-16/ccitt-false, one byte msb first
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc_in,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/crcf_front.sv
`default_nettype none
module crcf_front
  import crcf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LenW-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  input  wire logic [ByteW-1:0] in_data_i,
  output logic                  in_ready_o,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output crcf_entry_t           q_entry_o
);

  logic [LenW-1:0] payload_length_q;
  logic [LenW-1:0] bytes_seen_q, bytes_seen_d;
  logic [CrcW-1:0] crc_q, crc_d;
  logic [LenW-1:0] eff_len;
  logic [LenW-1:0] count_next;
  logic [CrcW-1:0] crc_new;
  logic            is_last;

  always_comb begin
    eff_len = payload_length_q;
    if (eff_len < LenMin) begin
      eff_len = LenMin;
    end
    if (eff_len > LenMax) begin
      eff_len = LenMax;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign crc_new    = crc_feed(crc_q, in_data_i);
  assign count_next = bytes_seen_q + 6'd1;
  assign is_last    = (count_next >= eff_len);

  always_comb begin
    q_entry_o.data     = in_data_i;
    q_entry_o.len_byte = {2'b00, eff_len} + 8'd2;
    q_entry_o.crc      = crc_new;
    q_entry_o.first    = (bytes_seen_q == '0);
    q_entry_o.last     = is_last;
  end

  always_comb begin
    bytes_seen_d = bytes_seen_q;
    crc_d        = crc_q;
    if (q_push_o) begin
      if (is_last) begin
        bytes_seen_d = '0;
        crc_d        = CrcInit;
      end else begin
        bytes_seen_d = count_next;
        crc_d        = crc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_length_q <= LenMax;
      bytes_seen_q     <= '0;
      crc_q            <= CrcInit;
    end else begin
      if (cfg_we_i) begin
        payload_length_q <= cfg_wdata_i;
      end
      bytes_seen_q <= bytes_seen_d;
      crc_q        <= crc_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crcf_fifo.sv
`default_nettype none
module crcf_fifo
  import crcf_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire crcf_entry_t push_entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output crcf_entry_t      head_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  Full     = CntW'(Depth);

  crcf_entry_t      mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crcf_back.sv
`default_nettype none
module crcf_back
  import crcf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire crcf_entry_t      head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      out_data_o,
  output logic                  out_last_o
);

  crcf_phase_e      phase_q, phase_d, cur, nxt;
  logic             started_q, started_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_data_q, out_data_d;
  logic             out_last_q, out_last_d;
  logic             emit, done;
  logic [ByteW-1:0] sel_byte;
  logic             sel_last;

  assign emit = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    cur = started_q ? phase_q : (head_i.first ? PH_SYNC0 : PH_DATA);
    sel_byte = head_i.data;
    sel_last = 1'b0;
    done     = 1'b0;
    nxt      = PH_DATA;
    unique case (cur)
      PH_SYNC0: begin
        sel_byte = SyncWord[15:8];
        nxt      = PH_SYNC1;
      end
      PH_SYNC1: begin
        sel_byte = SyncWord[7:0];
        nxt      = PH_LEN;
      end
      PH_LEN: begin
        sel_byte = head_i.len_byte;
        nxt      = PH_DATA;
      end
      PH_DATA: begin
        sel_byte = head_i.data;
        nxt      = PH_CRCLO;
        done     = !head_i.last;
      end
      PH_CRCLO: begin
        sel_byte = head_i.crc[7:0];
        nxt      = PH_CRCHI;
      end
      PH_CRCHI: begin
        sel_byte = head_i.crc[15:8];
        sel_last = 1'b1;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    started_d   = started_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = sel_byte;
      out_last_d  = sel_last;
      started_d   = !done;
      phase_d     = nxt;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign pop_o       = emit && done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

endmodule
`default_nettype wire

FILE: rtl/crc16_packet_framer_unit.sv
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] payload_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[7:0] frame_byte, tlast frame_end
// cfg       in   cfg_we_i (no wait)           cfg_wdata_i[5:0] payload_length
//
// a payload word enters the queue at the edge that accepts it, with its crc updated
// in that cycle, and reaches m_axis from the queue through the back's output register.
// the back emits one word a cycle unless m_axis stalls; the queue absorbs bursts:
// a first word follows sync and length bytes, a closing one precedes crc bytes.
// reset clears the length to 59, the crc to ffff and the queue; no clearing pass.
// a stalled m_axis holds its word; s_axis stalls only when the queue is full.
`default_nettype none
module crc16_packet_framer_unit
  import crcf_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LenW-1:0]  cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [ByteW-1:0] s_axis_tdata,   // [7:0] payload_byte
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [ByteW-1:0]      m_axis_tdata,   // [7:0] frame_byte
  output logic                  m_axis_tlast    // frame_end
);

  crcf_entry_t push_entry, head;
  logic        push, pop, full, empty;

  crcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_entry_o   (push_entry)
  );

  crcf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  crcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/crcf_checker.sv
`default_nettype none
module crcf_checker
  import crcf_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [ByteW-1:0] m_axis_tdata,
  input wire logic             m_axis_tlast
);

  logic frame_start_q;
  logic seen_in_q;
  logic prev_sync_q;
  logic m_acc;

  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= 1'b1;
      seen_in_q     <= 1'b0;
      prev_sync_q   <= 1'b0;
    end else begin
      if (m_acc) begin
        frame_start_q <= m_axis_tlast;
        prev_sync_q   <= frame_start_q;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_in_q <= 1'b1;
      end
    end
  end

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // every frame opens with the sync pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && frame_start_q |-> m_axis_tdata == SyncWord[15:8] && !m_axis_tlast)
    else $error("frame does not open with first sync byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && prev_sync_q |-> m_axis_tdata == SyncWord[7:0] && !m_axis_tlast)
    else $error("second sync byte missing");

  // no output before any payload word came in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seen_in_q)
    else $error("output word without any input");

endmodule

bind crc16_packet_framer_unit crcf_checker u_crcf_checker (.*);
`default_nettype wire

FILE: test/crc16_packet_framer_checker.sv
module crc16_packet_framer_checker
  import crcf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LenW-1:0]  cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  input  wire logic             s_axis_tready,
  input  wire logic [ByteW-1:0] s_axis_tdata,
  input  wire logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire logic [ByteW-1:0] m_axis_tdata,
  input  wire logic             m_axis_tlast,
  output int                    mismatch_cnt_o,
  output int                    words_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } frame_word_t;

  frame_word_t      owed_q[$];
  frame_word_t      head;
  logic [LenW-1:0]  len_reg;
  logic [LenW-1:0]  tally;
  logic [CrcW-1:0]  crc_acc;

  // bit-serial form: feedback is crc msb xor data bit
  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] c,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] r;
    logic            fb;
    r = c;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = r[CrcW-1] ^ b[i];
      r  = {r[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return r;
  endfunction

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
    if (v < LenMin) begin
      return LenMin;
    end
    if (v > LenMax) begin
      return LenMax;
    end
    return v;
  endfunction

  task automatic predict_frame_bytes(input logic [ByteW-1:0] b);
    logic [LenW-1:0] eff;
    eff = clamp_len(len_reg);
    if (tally == '0) begin
      owed_q.push_back('{SyncWord[15:8], 1'b0});
      owed_q.push_back('{SyncWord[7:0], 1'b0});
      owed_q.push_back('{{2'b00, eff} + 8'd2, 1'b0});
    end
    crc_acc = crc_step(crc_acc, b);
    owed_q.push_back('{b, 1'b0});
    tally = tally + 1'b1;
    // closes on reaching or passing the count, even after a mid-frame change
    if (tally >= eff) begin
      owed_q.push_back('{crc_acc[7:0], 1'b0});
      owed_q.push_back('{crc_acc[15:8], 1'b1});
      crc_acc = CrcInit;
      tally   = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q.delete();
      len_reg        = LenMax;
      tally          = '0;
      crc_acc        = CrcInit;
      mismatch_cnt_o = 0;
      words_owed_o   = 0;
    end else begin
      if (cfg_we_i) begin
        len_reg = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_frame_bytes(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual byte %02h last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          mismatch_cnt_o++;
        end else begin
          head = owed_q.pop_front();
          if (m_axis_tdata !== head.data) begin
            $display("%0t: frame_byte expected %02h actual %02h",
                     $time, head.data, m_axis_tdata);
            mismatch_cnt_o++;
          end
          if (m_axis_tlast !== head.last) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, head.last, m_axis_tlast);
            mismatch_cnt_o++;
          end
        end
      end
      words_owed_o = owed_q.size();
    end
  end

endmodule

FILE: test/crc16_packet_framer_unit_tb.sv
module crc16_packet_framer_unit_tb;
  import crcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 410;
  localparam int HoldCycles  = 100;
  localparam int CycleLimit  = 100000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LenW-1:0]  cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata;   // [7:0] payload_byte
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [ByteW-1:0] m_axis_tdata;   // [7:0] frame_byte
  logic             m_axis_tlast;   // frame_end

  int   mismatch_cnt;
  int   words_owed;
  int   items_sent;
  int   cycle_cnt;
  logic calm;
  logic hold_req;

  always #10 clk_i = ~clk_i;

  crc16_packet_framer_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  crc16_packet_framer_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatch_cnt_o(mismatch_cnt),
    .words_owed_o  (words_owed)
  );

  // returns at the falling edge after the word is taken, tvalid still high
  task automatic push_payload(input logic [ByteW-1:0] b);
    while (!calm && $urandom_range(99, 0) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (words_owed != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_len(input logic [LenW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [LenW-1:0] pick_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 6) begin
      return '0;
    end else if (r < 12) begin
      return LenW'($urandom_range(63, 59));
    end else if (r < 20) begin
      return LenMin;
    end else if (r < 30) begin
      return LenW'($urandom_range(40, 11));
    end
    return LenW'($urandom_range(10, 2));
  endfunction

  // receiver: random back-pressure plus one long hold while input keeps coming
  initial begin
    logic held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99, 0) >= 12);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [LenW-1:0] lv;
    int              eff;
    int              n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // frame opened at the reset length, then closed early by a shorter one
    push_payload(8'h00);
    push_payload(8'hFF);
    settle();
    write_len(LenMin);
    push_payload(8'h5A);
    push_payload(8'h00);
    push_payload(8'hFF);
    settle();
    // zero acts as one
    write_len('0);
    push_payload(8'h80);
    push_payload(8'h01);
    settle();
    write_len(6'd3);
    push_payload(8'h7F);
    push_payload(8'hFE);
    push_payload(8'h55);
    push_payload(8'hAA);
    settle();
    write_len(6'd6);
    push_payload(8'h12);
    push_payload(8'h34);
    settle();
    // above the top acts as 59
    write_len(6'd63);
    push_payload(8'hC3);
    push_payload(8'h3C);
    settle();
    write_len(6'd2);
    push_payload(8'h01);
    settle();

    n = items_sent + RandomItems;
    while (items_sent < n) begin
      settle();
      lv = pick_len();
      write_len(lv);
      eff = (lv < LenMin) ? LenMin : (lv > LenMax) ? LenMax : lv;
      repeat ((eff <= 10) ? $urandom_range(40, 5) : eff + $urandom_range(10, 0)) begin
        calm <= (items_sent >= 220 && items_sent < 300);
        if (items_sent == 120) begin
          hold_req <= 1'b1;
        end
        push_payload(ByteW'($urandom_range(255, 0)));
      end
    end
    settle();
    repeat (10) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
